// File: rtl/segi_pkg.sv
`timescale 1ns / 1ps

package segi_pkg;

   // Coordinate format shared by every port and stage.
   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_DEFAULT = 16;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   wide_type;
   typedef logic [COORD_WIDTH-1:0]        mag_type;
   typedef logic [2*COORD_WIDTH-1:0]      prod_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // One input beat: the two segments.
   typedef struct packed {
      coord_type a_x1;
      coord_type a_z1;
      coord_type a_x2;
      coord_type a_z2;
      coord_type b_x1;
      coord_type b_z1;
      coord_type b_x2;
      coord_type b_z2;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic      hit;
      coord_type cross_x;
      coord_type cross_z;
   } rsp_type;

   // Sign extension by one bit.
   function automatic wide_type sx(coord_type v);
      return {v[COORD_WIDTH-1], v};
   endfunction

   // Saturate a one-bit-wider value to the coordinate range.
   function automatic coord_type clamp(wide_type v);
      coord_type r;
      if (v[COORD_WIDTH] != v[COORD_WIDTH-1]) begin
         r = v[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // Magnitude of a coordinate; the most negative value maps to 2^(W-1).
   function automatic mag_type abs_c(coord_type v);
      mag_type r;
      if (v[COORD_WIDTH-1]) begin
         r = mag_type'(-v);
      end else begin
         r = mag_type'(v);
      end
      return r;
   endfunction

   // Apply a sign to a magnitude, saturating when the magnitude overflowed.
   function automatic coord_type sat_mag(logic [COORD_WIDTH-2:0] mag, logic ovf, logic neg);
      coord_type r;
      if (ovf) begin
         r = neg ? COORD_MIN : COORD_MAX;
      end else if (neg) begin
         r = -$signed({1'b0, mag});
      end else begin
         r = $signed({1'b0, mag});
      end
      return r;
   endfunction

endpackage

// File: rtl/segi_div.sv
`timescale 1ns / 1ps

// Pipelined fixed-point divider: q = n * 2^FRAC_BITS / d, truncated toward
// zero and saturated. One quotient bit per stage, several lanes side by side.
module segi_div
   import segi_pkg::*;
#(
   parameter int LANES     = 2,
   parameter int FRAC_BITS = FRAC_DEFAULT,
   parameter int TAG_W     = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [LANES-1:0][COORD_WIDTH:0]    in_num,
   input  logic [LANES-1:0][COORD_WIDTH:0]    in_den,
   input  logic [TAG_W-1:0]                   in_tag,
   output logic                               out_valid,
   output logic [LANES-1:0][COORD_WIDTH-1:0]  out_quo,
   output logic [TAG_W-1:0]                   out_tag
);

   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int NB    = MAG_W + FRAC_BITS;

   logic [MAG_W-1:0]       rem_ff [0:NB][0:LANES-1];
   logic [MAG_W-1:0]       rem_in [0:NB][0:LANES-1];
   logic [NB-1:0]          num_ff [0:NB][0:LANES-1];
   logic [NB-1:0]          num_in [0:NB][0:LANES-1];
   logic [MAG_W-1:0]       den_ff [0:NB][0:LANES-1];
   logic [MAG_W-1:0]       den_in [0:NB][0:LANES-1];
   logic [COORD_WIDTH-2:0] quo_ff [0:NB][0:LANES-1];
   logic [COORD_WIDTH-2:0] quo_in [0:NB][0:LANES-1];
   logic                   ovf_ff [0:NB][0:LANES-1];
   logic                   ovf_in [0:NB][0:LANES-1];
   logic                   neg_ff [0:NB][0:LANES-1];
   logic                   neg_in [0:NB][0:LANES-1];
   logic                   val_ff [0:NB];
   logic [TAG_W-1:0]       tag_ff [0:NB];

   logic [LANES-1:0][COORD_WIDTH-1:0] quo_out_ff;
   logic                              val_out_ff;
   logic [TAG_W-1:0]                  tag_out_ff;

   // Entry: magnitudes and result sign, then one restoring step per stage.
   always_comb begin
      logic [MAG_W-1:0] nm;
      logic [MAG_W-1:0] dm;
      logic [MAG_W:0]   t;
      logic [MAG_W:0]   diff;
      logic             ge;
      for (int l = 0; l < LANES; l++) begin
         nm = in_num[l][COORD_WIDTH] ? (~in_num[l] + 1'b1) : in_num[l];
         dm = in_den[l][COORD_WIDTH] ? (~in_den[l] + 1'b1) : in_den[l];
         rem_in[0][l] = '0;
         num_in[0][l] = {nm, {FRAC_BITS{1'b0}}};
         den_in[0][l] = dm;
         quo_in[0][l] = '0;
         ovf_in[0][l] = 1'b0;
         neg_in[0][l] = in_num[l][COORD_WIDTH] ^ in_den[l][COORD_WIDTH];
      end
      for (int s = 0; s < NB; s++) begin
         for (int l = 0; l < LANES; l++) begin
            t    = {rem_ff[s][l], num_ff[s][l][NB-1]};
            diff = t - {1'b0, den_ff[s][l]};
            ge   = t >= {1'b0, den_ff[s][l]};
            rem_in[s+1][l] = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
            num_in[s+1][l] = {num_ff[s][l][NB-2:0], 1'b0};
            den_in[s+1][l] = den_ff[s][l];
            quo_in[s+1][l] = {quo_ff[s][l][COORD_WIDTH-3:0], ge};
            // A bit pushed out of the top means the quotient overflows.
            ovf_in[s+1][l] = ovf_ff[s][l] | quo_ff[s][l][COORD_WIDTH-2];
            neg_in[s+1][l] = neg_ff[s][l];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NB; s++) begin
            val_ff[s] <= 1'b0;
         end
         val_out_ff <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
         for (int s = 1; s <= NB; s++) begin
            val_ff[s] <= val_ff[s-1];
         end
         val_out_ff <= val_ff[NB];
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
         ovf_ff <= ovf_in;
         neg_ff <= neg_in;
         tag_ff[0] <= in_tag;
         for (int s = 1; s <= NB; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         for (int l = 0; l < LANES; l++) begin
            quo_out_ff[l] <= sat_mag(quo_ff[NB][l], ovf_ff[NB][l], neg_ff[NB][l]);
         end
         tag_out_ff <= tag_ff[NB];
      end
   end

   assign out_valid = val_out_ff;
   assign out_quo   = quo_out_ff;
   assign out_tag   = tag_out_ff;

endmodule

// File: rtl/segment_segment_intersect_2d.sv
`timescale 1ns / 1ps

// The datapath runs through three chained pipelined dividers (slopes, crossing x,
// ratios).
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output and is not taken.
// Reset clears every valid bit; data registers are not reset.
module segment_segment_intersect_2d
   import segi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam coord_type FX_ONE = coord_type'(1) << FRAC_BITS;

   // Working set of one segment pair as it travels down the pipeline.
   typedef struct packed {
      logic                 va;
      logic                 vb;
      logic                 hit;
      coord_type            ax1;
      coord_type            bx1;
      coord_type            az1;
      coord_type            az2;
      coord_type            bz1;
      coord_type            bz2;
      wide_type             dxa;
      wide_type             dza;
      wide_type             dxb;
      wide_type             dzb;
      coord_type            alo;
      coord_type            ahi;
      coord_type            blo;
      coord_type            bhi;
      coord_type            lo;
      coord_type            hi;
      coord_type            sa;
      coord_type            sb;
      coord_type            ia;
      coord_type            ib;
      coord_type            px;
      coord_type            pz;
      coord_type            vz;
      coord_type            x;
      coord_type            ra;
      coord_type            rb;
      wide_type             xn;
      wide_type             xd;
      wide_type             xa;
      wide_type             xb;
      mag_type              m_sa;
      mag_type              m_sb;
      mag_type              m_ax1;
      mag_type              m_bx1;
      mag_type              m_x;
      logic [3:0]           ps;
      logic                 nz;
      prod_type [3:0]       pr;
      prod_type             pxz;
      coord_type [3:0]      fm;
      coord_type            fz;
   } ctx_type;

   localparam int TAG_W = $bits(ctx_type);

   // Scale a magnitude product back to the coordinate format, with sign.
   function automatic coord_type mul_fin(prod_type p, logic neg);
      logic ovf;
      ovf = |p[2*COORD_WIDTH-1:FRAC_BITS+COORD_WIDTH-1];
      return sat_mag(p[FRAC_BITS+COORD_WIDTH-2:FRAC_BITS], ovf, neg);
   endfunction

   logic    adv;
   ctx_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in;
   ctx_type s5_ff, s5_in, s6_ff, s6_in, s7_ff, s7_in, s8_ff, s8_in;
   ctx_type s9_ff, s9_in, s10_ff, s10_in;
   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   logic                              d1_valid, d2_valid, d3_valid;
   logic [1:0][COORD_WIDTH-1:0]       d1_quo, d3_quo;
   logic [0:0][COORD_WIDTH-1:0]       d2_quo;
   logic [TAG_W-1:0]                  d1_tag, d2_tag, d3_tag;

   // The pipeline moves whenever the output register is free or being read.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Order each segment's endpoints by x and take the differences.
   always_comb begin
      logic swa;
      logic swb;
      swa = req_data.a_x1 > req_data.a_x2;
      swb = req_data.b_x1 > req_data.b_x2;
      s1_in     = '0;
      s1_in.va  = req_data.a_x1 == req_data.a_x2;
      s1_in.vb  = req_data.b_x1 == req_data.b_x2;
      s1_in.ax1 = swa ? req_data.a_x2 : req_data.a_x1;
      s1_in.az1 = swa ? req_data.a_z2 : req_data.a_z1;
      s1_in.az2 = swa ? req_data.a_z1 : req_data.a_z2;
      s1_in.bx1 = swb ? req_data.b_x2 : req_data.b_x1;
      s1_in.bz1 = swb ? req_data.b_z2 : req_data.b_z1;
      s1_in.bz2 = swb ? req_data.b_z1 : req_data.b_z2;
      s1_in.dxa = swa ? sx(req_data.a_x1) - sx(req_data.a_x2)
                      : sx(req_data.a_x2) - sx(req_data.a_x1);
      s1_in.dza = swa ? sx(req_data.a_z1) - sx(req_data.a_z2)
                      : sx(req_data.a_z2) - sx(req_data.a_z1);
      s1_in.dxb = swb ? sx(req_data.b_x1) - sx(req_data.b_x2)
                      : sx(req_data.b_x2) - sx(req_data.b_x1);
      s1_in.dzb = swb ? sx(req_data.b_z1) - sx(req_data.b_z2)
                      : sx(req_data.b_z2) - sx(req_data.b_z1);
   end

   // Slopes of both segments.
   segi_div #(
      .LANES     (2),
      .FRAC_BITS (FRAC_BITS),
      .TAG_W     (TAG_W)
   ) u_div_slope (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v1_ff),
      .in_num    ({s1_ff.dzb, s1_ff.dza}),
      .in_den    ({s1_ff.dxb, s1_ff.dxa}),
      .in_tag    (s1_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag)
   );

   // Magnitudes and signs for the four products, z extents of both segments.
   always_comb begin
      s2_in       = ctx_type'(d1_tag);
      s2_in.sa    = d1_quo[0];
      s2_in.sb    = d1_quo[1];
      s2_in.m_sa  = abs_c(d1_quo[0]);
      s2_in.m_sb  = abs_c(d1_quo[1]);
      s2_in.m_ax1 = abs_c(s2_in.ax1);
      s2_in.m_bx1 = abs_c(s2_in.bx1);
      s2_in.ps[0] = d1_quo[0][COORD_WIDTH-1] ^ s2_in.ax1[COORD_WIDTH-1];
      s2_in.ps[1] = d1_quo[1][COORD_WIDTH-1] ^ s2_in.bx1[COORD_WIDTH-1];
      s2_in.ps[2] = d1_quo[1][COORD_WIDTH-1] ^ s2_in.ax1[COORD_WIDTH-1];
      s2_in.ps[3] = d1_quo[0][COORD_WIDTH-1] ^ s2_in.bx1[COORD_WIDTH-1];
      s2_in.alo   = (s2_in.az1 < s2_in.az2) ? s2_in.az1 : s2_in.az2;
      s2_in.ahi   = (s2_in.az1 < s2_in.az2) ? s2_in.az2 : s2_in.az1;
      s2_in.blo   = (s2_in.bz1 < s2_in.bz2) ? s2_in.bz1 : s2_in.bz2;
      s2_in.bhi   = (s2_in.bz1 < s2_in.bz2) ? s2_in.bz2 : s2_in.bz1;
   end

   // Magnitude products and the overlap window of two vertical segments.
   always_comb begin
      s3_in       = s2_ff;
      s3_in.pr[0] = s2_ff.m_sa * s2_ff.m_ax1;
      s3_in.pr[1] = s2_ff.m_sb * s2_ff.m_bx1;
      s3_in.pr[2] = s2_ff.m_sb * s2_ff.m_ax1;
      s3_in.pr[3] = s2_ff.m_sa * s2_ff.m_bx1;
      s3_in.lo    = (s2_ff.alo > s2_ff.blo) ? s2_ff.alo : s2_ff.blo;
      s3_in.hi    = (s2_ff.ahi < s2_ff.bhi) ? s2_ff.ahi : s2_ff.bhi;
   end

   // Rescale the products; decide the case where both segments are vertical.
   always_comb begin
      s4_in = s3_ff;
      for (int i = 0; i < 4; i++) begin
         s4_in.fm[i] = mul_fin(s3_ff.pr[i], s3_ff.ps[i]);
      end
      if (s3_ff.va && s3_ff.vb && s3_ff.ax1 == s3_ff.bx1 && s3_ff.lo <= s3_ff.hi) begin
         s4_in.hit = 1'b1;
         s4_in.px  = s3_ff.ax1;
         s4_in.pz  = s3_ff.lo;
      end
   end

   // Intercepts.
   always_comb begin
      s5_in    = s4_ff;
      s5_in.ia = clamp(sx(s4_ff.az1) - sx(s4_ff.fm[0]));
      s5_in.ib = clamp(sx(s4_ff.bz1) - sx(s4_ff.fm[1]));
   end

   // Candidate z where exactly one segment is vertical; crossing-x operands.
   always_comb begin
      s6_in = s5_ff;
      if (s5_ff.va && !s5_ff.vb) begin
         s6_in.vz = clamp(sx(s5_ff.fm[2]) + sx(s5_ff.ib));
         s6_in.px = s5_ff.ax1;
      end else if (s5_ff.vb && !s5_ff.va) begin
         s6_in.vz = clamp(sx(s5_ff.fm[3]) + sx(s5_ff.ia));
         s6_in.px = s5_ff.bx1;
      end
      s6_in.xn = sx(s5_ff.ib) - sx(s5_ff.ia);
      s6_in.xd = sx(s5_ff.sa) - sx(s5_ff.sb);
   end

   // Range check of the candidate against the vertical segment.
   always_comb begin
      s7_in = s6_ff;
      if (s6_ff.va && !s6_ff.vb && s6_ff.alo <= s6_ff.vz && s6_ff.vz <= s6_ff.ahi) begin
         s7_in.hit = 1'b1;
         s7_in.pz  = s6_ff.vz;
      end
      if (s6_ff.vb && !s6_ff.va && s6_ff.blo <= s6_ff.vz && s6_ff.vz <= s6_ff.bhi) begin
         s7_in.hit = 1'b1;
         s7_in.pz  = s6_ff.vz;
      end
   end

   // Crossing x of the two lines.
   segi_div #(
      .LANES     (1),
      .FRAC_BITS (FRAC_BITS),
      .TAG_W     (TAG_W)
   ) u_div_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_num    (s7_ff.xn),
      .in_den    (s7_ff.xd),
      .in_tag    (s7_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_tag   (d2_tag)
   );

   // Offsets of x from each segment's start.
   always_comb begin
      s8_in     = ctx_type'(d2_tag);
      s8_in.x   = d2_quo[0];
      s8_in.xa  = sx(d2_quo[0]) - sx(s8_in.ax1);
      s8_in.xb  = sx(d2_quo[0]) - sx(s8_in.bx1);
      s8_in.m_x = abs_c(d2_quo[0]);
      s8_in.nz  = d2_quo[0][COORD_WIDTH-1] ^ s8_in.sa[COORD_WIDTH-1];
   end

   // Segment parameters at the crossing.
   segi_div #(
      .LANES     (2),
      .FRAC_BITS (FRAC_BITS),
      .TAG_W     (TAG_W)
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v8_ff),
      .in_num    ({s8_ff.xb, s8_ff.xa}),
      .in_den    ({s8_ff.dxb, s8_ff.dxa}),
      .in_tag    (s8_ff),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_tag   (d3_tag)
   );

   // Product for the crossing z.
   always_comb begin
      s9_in     = ctx_type'(d3_tag);
      s9_in.ra  = d3_quo[0];
      s9_in.rb  = d3_quo[1];
      s9_in.pxz = s9_in.m_sa * s9_in.m_x;
   end

   // General case: both parameters within 0..1 and the slopes differ.
   always_comb begin
      s10_in    = s9_ff;
      s10_in.fz = mul_fin(s9_ff.pxz, s9_ff.nz);
      if (!s9_ff.va && !s9_ff.vb && s9_ff.sa != s9_ff.sb
          && !s9_ff.ra[COORD_WIDTH-1] && s9_ff.ra <= FX_ONE
          && !s9_ff.rb[COORD_WIDTH-1] && s9_ff.rb <= FX_ONE) begin
         s10_in.hit = 1'b1;
         s10_in.px  = s9_ff.x;
      end
   end

   // Result beat; the point reads zero on a miss.
   always_comb begin
      rsp_in.hit     = s10_ff.hit;
      rsp_in.cross_x = s10_ff.hit ? s10_ff.px : '0;
      if (!s10_ff.hit) begin
         rsp_in.cross_z = '0;
      end else if (!s10_ff.va && !s10_ff.vb) begin
         rsp_in.cross_z = clamp(sx(s10_ff.fz) + sx(s10_ff.ia));
      end else begin
         rsp_in.cross_z = s10_ff.pz;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= d1_valid;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= d2_valid;
         v9_ff        <= d3_valid;
         v10_ff       <= v9_ff;
         rsp_valid_ff <= v10_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         rsp_ff <= rsp_in;
      end
   end

   // A miss carries a zero point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.cross_x == '0 && rsp_data.cross_z == '0)
      else $error("miss beat with non-zero point");

   // A waiting result holds the input side.
   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // Two vertical segments only meet at a common x.
   a_vert_x: assert property (@(posedge clock) disable iff (reset)
      v4_ff && s4_ff.va && s4_ff.vb && s4_ff.hit |-> s4_ff.px == s4_ff.bx1)
      else $error("vertical pair hit at differing x");

   // Parallel lines never hit in the general case.
   a_parallel: assert property (@(posedge clock) disable iff (reset)
      v10_ff && s10_ff.hit && !s10_ff.va && !s10_ff.vb |-> s10_ff.sa != s10_ff.sb)
      else $error("hit reported for equal slopes");

endmodule

// File: tb/segi_checker.sv
`timescale 1ns / 1ps

module segi_checker
   import segi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      pending,
   output int      failures
);

   localparam longint LIMIT = longint'(1) <<< (COORD_WIDTH - 1);

   rsp_type expected_points[$];

   // Saturate a wide value to the coordinate range.
   function automatic longint clip(longint v);
      longint r;
      r = v;
      if (v > LIMIT - 1) r = LIMIT - 1;
      if (v < -LIMIT) r = -LIMIT;
      return r;
   endfunction

   // Give a sign to a magnitude, saturating when it does not fit.
   function automatic longint signed_mag(logic [127:0] m, logic neg);
      longint r;
      if (m >= 128'(LIMIT)) begin
         r = neg ? -LIMIT : LIMIT - 1;
      end else begin
         r = neg ? -longint'(m[63:0]) : longint'(m[63:0]);
      end
      return r;
   endfunction

   function automatic logic [127:0] magnitude(longint v);
      logic [127:0] r;
      r = (v < 0) ? 128'(-v) : 128'(v);
      return r;
   endfunction

   // Fixed-point product, truncated toward zero.
   function automatic longint fix_mul(longint a, longint b);
      logic [127:0] m;
      m = (magnitude(a) * magnitude(b)) >> FRAC_BITS;
      return signed_mag(m, (a < 0) != (b < 0));
   endfunction

   // Fixed-point quotient, truncated toward zero; a zero divisor yields zero.
   function automatic longint fix_div(longint n, longint d);
      logic [127:0] m;
      longint r;
      if (d == 0) begin
         r = 0;
      end else begin
         m = (magnitude(n) << FRAC_BITS) / magnitude(d);
         r = signed_mag(m, (n < 0) != (d < 0));
      end
      return r;
   endfunction

   function automatic logic between(longint v, longint p, longint q);
      longint lo, hi;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      return (lo <= v) && (v <= hi);
   endfunction

   // Work out the crossing of the two segments of one beat.
   function automatic rsp_type intersect_point(req_type r);
      longint ax1, az1, ax2, az2, bx1, bz1, bx2, bz2, t;
      longint sa, ia, sb, ib, px, pz, v, x, ra, rb, one;
      longint alo, ahi, blo, bhi, lo, hi;
      logic vert_a, vert_b, hit;
      rsp_type res;
      ax1 = r.a_x1; az1 = r.a_z1; ax2 = r.a_x2; az2 = r.a_z2;
      bx1 = r.b_x1; bz1 = r.b_z1; bx2 = r.b_x2; bz2 = r.b_z2;
      sa = 0; ia = 0; sb = 0; ib = 0; px = 0; pz = 0; hit = 1'b0;
      one = longint'(1) <<< FRAC_BITS;
      // Order each segment's endpoints by x.
      if (ax1 > ax2) begin
         t = ax1; ax1 = ax2; ax2 = t; t = az1; az1 = az2; az2 = t;
      end
      if (bx1 > bx2) begin
         t = bx1; bx1 = bx2; bx2 = t; t = bz1; bz1 = bz2; bz2 = t;
      end
      vert_a = (ax1 == ax2);
      vert_b = (bx1 == bx2);
      if (!vert_a) begin
         sa = fix_div(az2 - az1, ax2 - ax1);
         ia = clip(az1 - fix_mul(sa, ax1));
      end
      if (!vert_b) begin
         sb = fix_div(bz2 - bz1, bx2 - bx1);
         ib = clip(bz1 - fix_mul(sb, bx1));
      end
      if (vert_a && vert_b) begin
         // Both vertical: overlap of the z ranges on a common x.
         if (ax1 == bx1) begin
            alo = (az1 < az2) ? az1 : az2; ahi = (az1 < az2) ? az2 : az1;
            blo = (bz1 < bz2) ? bz1 : bz2; bhi = (bz1 < bz2) ? bz2 : bz1;
            lo = (alo > blo) ? alo : blo;
            hi = (ahi < bhi) ? ahi : bhi;
            if (lo <= hi) begin
               hit = 1'b1; px = ax1; pz = lo;
            end
         end
      end else if (vert_a) begin
         v = clip(fix_mul(sb, ax1) + ib);
         if (between(v, az1, az2)) begin
            hit = 1'b1; px = ax1; pz = v;
         end
      end else if (vert_b) begin
         v = clip(fix_mul(sa, bx1) + ia);
         if (between(v, bz1, bz2)) begin
            hit = 1'b1; px = bx1; pz = v;
         end
      end else if (sa != sb) begin
         // Equal slopes never hit, so only distinct slopes reach here.
         x = fix_div(ib - ia, sa - sb);
         ra = fix_div(x - ax1, ax2 - ax1);
         rb = fix_div(x - bx1, bx2 - bx1);
         if (ra >= 0 && ra <= one && rb >= 0 && rb <= one) begin
            hit = 1'b1; px = x; pz = clip(fix_mul(sa, x) + ia);
         end
      end
      res.hit = hit;
      res.cross_x = hit ? coord_type'(px) : '0;
      res.cross_z = hit ? coord_type'(pz) : '0;
      return res;
   endfunction

   assign pending = expected_points.size();

   // Predict on every input beat and compare on every result beat.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         failures <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_points.push_back(intersect_point(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("result beat with nothing expected");
               failures <= failures + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                  failures <= failures + 1;
               end else if (rsp_data.cross_x !== want.cross_x) begin
                  $error("cross_x: expected %0d, got %0d", want.cross_x, rsp_data.cross_x);
                  failures <= failures + 1;
               end else if (rsp_data.cross_z !== want.cross_z) begin
                  $error("cross_z: expected %0d, got %0d", want.cross_z, rsp_data.cross_z);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb_segment_segment_intersect_2d.sv
`timescale 1ns / 1ps

module tb_segment_segment_intersect_2d;
   import segi_pkg::*;

   localparam int RANDOM_PAIRS = 430;
   localparam int HOLD_CYCLES  = 400;

   typedef enum int {SHAPE_NOISE, SHAPE_SMALL, SHAPE_VERTICAL, SHAPE_EDGE} shape_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      pending;
   int      failures;
   int      accepted;

   segment_segment_intersect_2d i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   segi_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .pending   (pending),
      .failures  (failures)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Count accepted input beats for the receiver's hold-off.
   always @(posedge clock) begin
      if (reset) begin
         accepted <= 0;
      end else if (req_valid && req_ready) begin
         accepted <= accepted + 1;
      end
   end

   // Offer one beat and keep it up until it is taken.
   task automatic offer(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type pair(coord_type ax1, coord_type az1, coord_type ax2,
                                    coord_type az2, coord_type bx1, coord_type bz1,
                                    coord_type bx2, coord_type bz2);
      req_type r;
      r = '{ax1, az1, ax2, az2, bx1, bz1, bx2, bz2};
      return r;
   endfunction

   function automatic coord_type small_coord();
      return coord_type'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
   endfunction

   function automatic coord_type edge_coord();
      coord_type c;
      case ($urandom_range(0, 4))
         0: c = COORD_MIN;
         1: c = COORD_MAX;
         2: c = '0;
         3: c = coord_type'(32'sh0001_0000);
         default: c = coord_type'($urandom);
      endcase
      return c;
   endfunction

   // Random segment pair; mostly modest geometry so that crossings occur.
   function automatic req_type random_pair();
      req_type r;
      shape_type shape;
      shape = shape_type'($urandom_range(0, 9) < 2 ? SHAPE_NOISE :
                          $urandom_range(0, 9) < 6 ? SHAPE_SMALL :
                          $urandom_range(0, 1) ? SHAPE_VERTICAL : SHAPE_EDGE);
      case (shape)
         SHAPE_NOISE: begin
            r = req_type'({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
         end
         SHAPE_EDGE: begin
            r = pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord());
         end
         default: begin
            r = pair(small_coord(), small_coord(), small_coord(), small_coord(),
                     small_coord(), small_coord(), small_coord(), small_coord());
            if (shape == SHAPE_VERTICAL) begin
               if ($urandom_range(0, 2) != 0) r.a_x2 = r.a_x1;
               if ($urandom_range(0, 2) != 0) r.b_x2 = r.b_x1;
               if ($urandom_range(0, 1)) r.b_x1 = r.a_x1;
               if (r.b_x2 == r.a_x2 && r.a_x1 == r.a_x2) r.b_x2 = r.b_x1;
            end
         end
      endcase
      return r;
   endfunction

   // Receiver: random stalls, a calm stretch, and one long hold-off.
   initial begin
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (!held && accepted >= 200) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (accepted > 60 && accepted < 120) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            @(posedge clock);
         end
      end
   end

   // Stimulus.
   initial begin
      req_type d[$];
      int burst;
      bit drained;
      drained   = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs: crossings, each vertical case, parallels and extremes.
      d.push_back(pair(-32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000,
                       -32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000));
      d.push_back(pair(32'sh10000, 32'sh10000, -32'sh10000, -32'sh10000,
                       32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000));
      d.push_back(pair(0, 0, 32'sh10000, 0, 32'sh20000, 0, 32'sh30000, 32'sh10000));
      d.push_back(pair(0, 0, 0, 32'sh20000, 0, 32'sh10000, 0, 32'sh30000));
      d.push_back(pair(0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000));
      d.push_back(pair(0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 32'sh20000));
      d.push_back(pair(0, -32'sh10000, 0, 32'sh10000, -32'sh10000, 0, 32'sh10000, 0));
      d.push_back(pair(0, 32'sh10000, 0, 32'sh20000, -32'sh10000, 0, 32'sh10000, 0));
      d.push_back(pair(-32'sh10000, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000));
      d.push_back(pair(-32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh20000, 0, 32'sh20000, 32'sh10000));
      d.push_back(pair(0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh20000));
      d.push_back(pair(0, 0, 32'sh20000, 32'sh20000, 32'sh10000, 32'sh10000, 32'sh30000, 32'sh30000));
      d.push_back(pair(0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 0));
      d.push_back(pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                       COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      d.push_back(pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      d.push_back(pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      d.push_back(pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                       COORD_MIN, 0, COORD_MAX, 0));
      d.push_back(pair(0, COORD_MIN, 1, COORD_MAX, 0, COORD_MAX, 1, COORD_MIN));
      d.push_back(pair(COORD_MIN, 0, COORD_MAX, 1, -1, COORD_MIN, 1, COORD_MAX));
      d.push_back(pair('1, '1, '1, '1, '1, '1, '1, '1));
      d.push_back(pair(0, 0, 0, 0, 0, 0, 0, 0));
      foreach (d[i]) offer(d[i]);

      // Random pairs in bursts, with one pause until the pipeline drains.
      for (int n = 0; n < RANDOM_PAIRS; n = n + burst) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst; k++) offer(random_pair());
         req_valid <= 1'b0;
         if (!drained && n + burst >= 300) begin
            drained = 1'b1;
            do @(posedge clock); while (pending != 0);
         end else if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow for the pipeline depth.
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("tb_segment_segment_intersect_2d OK");
      end else begin
         $display("tb_segment_segment_intersect_2d NOT OK");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("tb_segment_segment_intersect_2d NOT OK");
      $finish;
   end

endmodule
